@@ hw/rtl/pdic_pkg.sv @@
package pdic_pkg;

    // Field and register widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 8;
    localparam int GAIN_W       = 16;
    localparam int LIMIT_W      = 15;
    localparam int OUT_W        = 26;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int DEADBAND     = 2;

    // Request codes
    localparam logic REQ_STEP  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // |sample| * gain stays below 2^(SAMPLE_WIDTH + GAIN_W - 1)
    localparam int PROD_W    = SAMPLE_WIDTH + GAIN_W - 1;
    // Numerator shift: 2^FRAC_BITS/30 = 2^7/15, 2^FRAC_BITS/4000 = 2^3/125
    localparam int SHIFT_MAX = 7;
    localparam int X_W       = PROD_W + SHIFT_MAX;
    // Numerator is split at 2^16 so that the reciprocal multiply stays narrow
    localparam int SPLIT     = 16;
    localparam int XH_W      = X_W - SPLIT;
    localparam int S_W       = 24;
    localparam int RECIP_W   = 25;
    localparam int C1_W      = 6;
    localparam int C2_W      = 13;
    localparam int MAG_W     = XH_W + C2_W;
    // Clamp limit in fixed point and a clamped term
    localparam int LIM_W     = LIMIT_W + FRAC_BITS;
    localparam int TERM_W    = LIM_W + 1;

    // Constant divide by d of x = m << sh:
    //   x = xh * 2^16 + xl, 2^16 = c2 * d + c1
    //   x / d = c2 * xh + (c1 * xh + xl) / d, the last by reciprocal recip >> k
    typedef struct packed {
        logic [2:0]         sh;
        logic [C1_W-1:0]    c1;
        logic [C2_W-1:0]    c2;
        logic [RECIP_W-1:0] recip;
        logic [4:0]         k;
    } t_div_row;

    // Divide by 15 (P and D terms)
    localparam t_div_row ROW_PD = '{sh: 3'd7, c1: 6'd1, c2: 13'd4369,
                                   recip: 25'd17895698, k: 5'd28};
    // Divide by 125 (I term)
    localparam t_div_row ROW_I  = '{sh: 3'd3, c1: 6'd36, c2: 13'd524,
                                   recip: 25'd17179870, k: 5'd31};

    // Divisor rows selected by factor_set; both rows hold the same divisors
    localparam t_div_row PD_ROWS [2] = '{ROW_PD, ROW_PD};
    localparam t_div_row I_ROWS  [2] = '{ROW_I, ROW_I};

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP      = 3'd0,
        CFG_KI      = 3'd1,
        CFG_KD      = 3'd2,
        CFG_P_LIMIT = 3'd3,
        CFG_I_LIMIT = 3'd4,
        CFG_D_LIMIT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [LIMIT_W-1:0] p_limit;
        logic [LIMIT_W-1:0] i_limit;
        logic [LIMIT_W-1:0] d_limit;
    } t_cfg;

endpackage

@@ hw/rtl/pdic_cfg.sv @@
module pdic_cfg import pdic_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register file, write only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp      <= '0;
            r_cfg.ki      <= '0;
            r_cfg.kd      <= '0;
            r_cfg.p_limit <= '1;
            r_cfg.i_limit <= '1;
            r_cfg.d_limit <= '1;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KP:      r_cfg.kp      <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:      r_cfg.ki      <= i_cfg_data[GAIN_W-1:0];
                CFG_KD:      r_cfg.kd      <= i_cfg_data[GAIN_W-1:0];
                CFG_P_LIMIT: r_cfg.p_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_I_LIMIT: r_cfg.i_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_D_LIMIT: r_cfg.d_limit <= i_cfg_data[LIMIT_W-1:0];
                default:     ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/pdic_scale.sv @@
module pdic_scale import pdic_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_en1,
    input  logic                           i_en2,
    input  logic                           i_en3,
    input  logic signed [SAMPLE_WIDTH-1:0] i_value,
    input  logic [GAIN_W-1:0]              i_gain,
    input  t_div_row                       i_row,
    output logic [MAG_W-1:0]               o_mag,
    output logic                           o_neg
);

    logic [SAMPLE_WIDTH-1:0]        abs_v;
    logic [SAMPLE_WIDTH+GAIN_W-1:0] prod;
    logic [X_W-1:0]                 x;
    logic [XH_W-1:0]                xh;
    logic [SPLIT-1:0]               xl;
    logic [XH_W+C1_W-1:0]           s_full;
    logic [MAG_W-1:0]               hi;
    logic [S_W+RECIP_W-1:0]         lo_prod;
    logic [S_W+RECIP_W-1:0]         lo_full;
    logic [MAG_W-1:0]               q;

    logic [PROD_W-1:0] r_m1;
    logic              r_neg1;
    t_div_row          r_row1;
    logic [S_W-1:0]    r_s2;
    logic [MAG_W-1:0]  r_hi2;
    logic              r_neg2;
    t_div_row          r_row2;
    logic [MAG_W-1:0]  r_q3;
    logic              r_neg3;

    // Stage 1: magnitude times gain
    assign abs_v = i_value[SAMPLE_WIDTH-1] ? $unsigned(-i_value) : $unsigned(i_value);
    assign prod  = abs_v * i_gain;

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_m1   <= prod[PROD_W-1:0];
            r_neg1 <= i_value[SAMPLE_WIDTH-1];
            r_row1 <= i_row;
        end
    end

    // Stage 2: split numerator, fold high part by constant multiplies
    assign x      = X_W'(r_m1) << r_row1.sh;
    assign xh     = x[X_W-1:SPLIT];
    assign xl     = x[SPLIT-1:0];
    assign s_full = xh * r_row1.c1 + (XH_W+C1_W)'(xl);
    assign hi     = xh * r_row1.c2;

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_s2   <= s_full[S_W-1:0];
            r_hi2  <= hi;
            r_neg2 <= r_neg1;
            r_row2 <= r_row1;
        end
    end

    // Stage 3: reciprocal multiply on the folded remainder part
    assign lo_prod = r_s2 * r_row2.recip;
    assign lo_full = lo_prod >> r_row2.k;
    assign q       = r_hi2 + MAG_W'(lo_full[S_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_q3   <= q;
            r_neg3 <= r_neg2;
        end
    end

    assign o_mag = r_q3;
    assign o_neg = r_neg3;

endmodule

@@ hw/rtl/pid_deadband_integral_clamped_core.sv @@
// PID step with integral deadband and symmetric per-term limits.
// Pipeline from the accepting edge to o_valid: input register, three
// scaling stages, term and integral stage, output register.
// Throughput: one word per cycle unless stalled; the integral add and clamp close in one stage.
// Reset (i_rst_n low, synchronous): pipeline empty, gains 0, limits 32767,
// previous error and integral 0.
module pid_deadband_integral_clamped_core import pdic_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_req_type,
    input  logic signed [SAMPLE_WIDTH-1:0] i_error_value,
    input  logic                           i_factor_set,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [OUT_W-1:0]        o_control_output,
    input  logic                           i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data
);

    localparam int INC_MAG_W = 28;
    localparam int ACC_W     = INC_MAG_W + 2;
    localparam logic signed [SAMPLE_WIDTH-1:0] DB_POS = SAMPLE_WIDTH'(DEADBAND);
    localparam logic signed [SAMPLE_WIDTH-1:0] DB_NEG = -DB_POS;
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    t_cfg cfg;

    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;
    logic acc;
    logic signed [SAMPLE_WIDTH:0]   delta_full;
    logic signed [SAMPLE_WIDTH-1:0] delta_sat;
    logic                           outside_db;
    logic signed [SAMPLE_WIDTH-1:0] i_val;
    t_div_row                       row_pd;
    t_div_row                       row_i;
    logic [MAG_W-1:0]               mag_p, mag_i, mag_d;
    logic                           neg_p, neg_i, neg_d;
    logic [LIM_W-1:0]               lim_p, lim_i, lim_d;
    logic signed [TERM_W-1:0]       term_p, term_d;
    logic signed [INC_MAG_W:0]      inc;
    logic signed [ACC_W-1:0]        acc_sum;
    logic signed [ACC_W-1:0]        lim_i_pos, lim_i_neg, acc_clamp;
    logic signed [OUT_W-1:0]        sum3;

    logic                           r_v0, r_v1, r_v2, r_v3, r_v4;
    logic                           r_c0, r_c1, r_c2, r_c3;
    logic signed [SAMPLE_WIDTH-1:0] r_s0_err;
    logic signed [SAMPLE_WIDTH-1:0] r_s0_delta;
    logic                           r_s0_fset;
    logic signed [SAMPLE_WIDTH-1:0] r_prev_err;
    logic signed [TERM_W-1:0]       r_int;
    logic signed [TERM_W-1:0]       r_p4, r_i4, r_d4;
    logic                           r_out_valid;
    logic signed [OUT_W-1:0]        r_out;

    function automatic logic signed [TERM_W-1:0] sym_term(
        input logic [MAG_W-1:0] mag,
        input logic             neg,
        input logic [LIM_W-1:0] lim
    );
        logic [LIM_W-1:0] m;
        m = (mag > MAG_W'(lim)) ? lim : mag[LIM_W-1:0];
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    pdic_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Ready chain: a stage moves when it is empty or the next one moves
    assign rdy5    = !r_out_valid || !i_stall;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign rdy0    = !r_v0 || rdy1;
    assign o_stall = !rdy0;
    assign acc     = i_valid && rdy0;

    // Input stage: saturated difference against the error of the last step request
    assign delta_full = {i_error_value[SAMPLE_WIDTH-1], i_error_value}
                      - {r_prev_err[SAMPLE_WIDTH-1], r_prev_err};
    always_comb begin
        if (delta_full[SAMPLE_WIDTH] != delta_full[SAMPLE_WIDTH-1]) begin
            delta_sat = delta_full[SAMPLE_WIDTH] ? S_MIN : S_MAX;
        end else begin
            delta_sat = delta_full[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_prev_err <= '0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_valid;
            end
            if (acc && (i_req_type == REQ_STEP)) begin
                r_prev_err <= i_error_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_c0       <= (i_req_type == REQ_CLEAR);
            r_s0_err   <= i_error_value;
            r_s0_delta <= delta_sat;
            r_s0_fset  <= i_factor_set;
        end
    end

    // Deadband: inside it the integral increment is zero
    assign outside_db = (r_s0_err > DB_POS) || (r_s0_err < DB_NEG);
    assign i_val      = outside_db ? r_s0_err : '0;
    assign row_pd     = PD_ROWS[r_s0_fset];
    assign row_i      = I_ROWS[r_s0_fset];

    // Scaling pipelines, one per term
    pdic_scale u_scale_p (
        .i_clk   (i_clk),
        .i_en1   (rdy1),
        .i_en2   (rdy2),
        .i_en3   (rdy3),
        .i_value (r_s0_err),
        .i_gain  (cfg.kp),
        .i_row   (row_pd),
        .o_mag   (mag_p),
        .o_neg   (neg_p)
    );

    pdic_scale u_scale_i (
        .i_clk   (i_clk),
        .i_en1   (rdy1),
        .i_en2   (rdy2),
        .i_en3   (rdy3),
        .i_value (i_val),
        .i_gain  (cfg.ki),
        .i_row   (row_i),
        .o_mag   (mag_i),
        .o_neg   (neg_i)
    );

    pdic_scale u_scale_d (
        .i_clk   (i_clk),
        .i_en1   (rdy1),
        .i_en2   (rdy2),
        .i_en3   (rdy3),
        .i_value (r_s0_delta),
        .i_gain  (cfg.kd),
        .i_row   (row_pd),
        .o_mag   (mag_d),
        .o_neg   (neg_d)
    );

    // Valid and clear flags alongside the scaling stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_c1 <= r_c0;
        if (rdy2) r_c2 <= r_c1;
        if (rdy3) r_c3 <= r_c2;
    end

    // Term stage: clamp P and D, accumulate and clamp the integral
    assign lim_p  = LIM_W'({cfg.p_limit, {FRAC_BITS{1'b0}}});
    assign lim_i  = LIM_W'({cfg.i_limit, {FRAC_BITS{1'b0}}});
    assign lim_d  = LIM_W'({cfg.d_limit, {FRAC_BITS{1'b0}}});
    assign term_p = sym_term(mag_p, neg_p, lim_p);
    assign term_d = sym_term(mag_d, neg_d, lim_d);

    assign inc       = neg_i ? -$signed({1'b0, mag_i[INC_MAG_W-1:0]})
                             : $signed({1'b0, mag_i[INC_MAG_W-1:0]});
    assign acc_sum   = ACC_W'(r_int) + ACC_W'(inc);
    assign lim_i_pos = $signed(ACC_W'(lim_i));
    assign lim_i_neg = -lim_i_pos;

    always_comb begin
        if (acc_sum > lim_i_pos) begin
            acc_clamp = lim_i_pos;
        end else if (acc_sum < lim_i_neg) begin
            acc_clamp = lim_i_neg;
        end else begin
            acc_clamp = acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4  <= 1'b0;
            r_int <= '0;
        end else if (rdy4) begin
            r_v4 <= r_v3 && !r_c3;
            if (r_v3) begin
                r_int <= r_c3 ? '0 : acc_clamp[TERM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_p4 <= term_p;
            r_i4 <= acc_clamp[TERM_W-1:0];
            r_d4 <= term_d;
        end
    end

    // Output register: sum of the clamped terms
    assign sum3 = OUT_W'(r_p4) + OUT_W'(r_i4) + OUT_W'(r_d4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy5) begin
            r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_out <= sum3;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_control_output = r_out;

    // A clear word zeroes the integral and yields no result
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_c3 && rdy4) |=> (r_int == '0))
        else $error("integral not cleared");

    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_c3 && rdy4) |=> !r_v4)
        else $error("clear word produced a result");

    // A held term word keeps its value
    a_term_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !rdy4) |=> (r_v4 && $stable(r_p4) && $stable(r_i4) && $stable(r_d4)))
        else $error("term stage lost a held word");

    // Previous error follows each accepted step request
    a_prev_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req_type == REQ_STEP)) |=> (r_prev_err == $past(i_error_value)))
        else $error("previous error not updated");

endmodule
